[sv/front_panel_button_led_controller_top_assert.svh]
// Assertion macros for the front-panel controller.
// Both expect clk_i and rst_ni in scope at the point of use.
`ifndef FRONT_PANEL_BUTTON_LED_CONTROLLER_TOP_ASSERT_SVH
`define FRONT_PANEL_BUTTON_LED_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define FPBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define FPBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FPBL_ASSERT(lbl, prop, msg)

`define FPBL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/fpbl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fpbl_pkg;

  localparam int unsigned NumBtn    = 6;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned NumTgt    = 4;
  localparam int unsigned UpBit     = 6;
  localparam int unsigned DownBit   = 7;
  localparam int unsigned SpeedSlot = 3;

  localparam logic [6:0] HoldTicksReset = 7'd32;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_WR_BYTE    = 3'd1,
    OP_WR_STOP    = 3'd2,
    OP_RD_PRESSED = 3'd3,
    OP_RD_HELD    = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] buttons_n;
    logic       scroll_cw;
    logic       scroll_ccw;
    logic [7:0] wr_data;
  } fpbl_in_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } fpbl_out_t;

endpackage

`default_nettype wire

[sv/fpbl_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module fpbl_core
  import fpbl_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire fpbl_in_t  req_i,
  input  wire logic      cfg_we_i,
  input  wire logic [6:0] cfg_data_i,
  output fpbl_out_t      rsp_o
);

  logic [6:0]             hold_q, hold_d;
  logic [NumBtn-1:0]      prev_down_q, prev_down_d;
  logic [6:0]             cnt_q [NumBtn];
  logic [6:0]             cnt_d [NumBtn];
  logic [2:0]             up_cnt_q, up_cnt_d;
  logic [2:0]             dn_cnt_q, dn_cnt_d;
  logic [7:0]             pressed_q, pressed_d;
  logic [NumBtn-1:0]      held_q, held_d;
  logic [7:0]             tgt_q [NumTgt];
  logic [7:0]             tgt_d [NumTgt];
  logic [7:0]             lvl_q [NumChan];
  logic [7:0]             lvl_d [NumChan];
  logic [7:0]             step_q, step_d;
  logic [1:0]             slot_q, slot_d;

  logic [NumBtn-1:0]      down;
  logic [7:0]             edge_flags;
  logic [7:0]             cnt_inc [NumBtn];
  logic [7:0]             rd_data;

  // Move one step toward the target; land on it within one step or when step is 0.
  function automatic logic [7:0] ramp(input logic [7:0] cur, input logic [7:0] tgt,
                                      input logic [7:0] step);
    logic [7:0] res;
    res = tgt;
    if (step != 8'd0) begin
      if ((tgt < cur) && ((cur - tgt) > step)) begin
        res = cur - step;
      end else if ((tgt > cur) && ((tgt - cur) > step)) begin
        res = cur + step;
      end
    end
    return res;
  endfunction

  assign down = ~req_i.buttons_n;

  always_comb begin
    hold_d      = hold_q;
    prev_down_d = prev_down_q;
    up_cnt_d    = up_cnt_q;
    dn_cnt_d    = dn_cnt_q;
    pressed_d   = pressed_q;
    held_d      = held_q;
    step_d      = step_q;
    slot_d      = slot_q;
    rd_data     = 8'd0;
    edge_flags  = {2'b00, req_i.buttons_n & prev_down_q};
    for (int i = 0; i < NumBtn; i++) begin
      cnt_d[i]   = cnt_q[i];
      cnt_inc[i] = {1'b0, cnt_q[i]} + 8'd1;
    end
    for (int i = 0; i < NumTgt; i++) begin
      tgt_d[i] = tgt_q[i];
    end
    for (int i = 0; i < NumChan; i++) begin
      lvl_d[i] = lvl_q[i];
    end

    if (cfg_we_i) begin
      hold_d = cfg_data_i;
    end

    if (en_i) begin
      unique case (req_i.op)
        OP_TICK: begin
          prev_down_d = down;
          for (int i = 0; i < NumBtn; i++) begin
            if (down[i]) begin
              if (cnt_inc[i] > {1'b0, hold_q}) begin
                held_d[i] = 1'b1;
                cnt_d[i]  = hold_q;
              end else begin
                cnt_d[i] = cnt_inc[i][6:0];
              end
            end else begin
              // Release after a hold is not a press.
              if (held_q[i]) begin
                edge_flags[i] = 1'b0;
                held_d[i]     = 1'b0;
              end
              cnt_d[i] = 7'd0;
            end
          end
          // Clockwise bumps the down count, counter-clockwise the up count.
          if (req_i.scroll_cw) begin
            dn_cnt_d = dn_cnt_q + 3'd1;
          end
          if (req_i.scroll_ccw) begin
            up_cnt_d = up_cnt_q + 3'd1;
          end
          edge_flags[UpBit]   = (up_cnt_d != 3'd0);
          edge_flags[DownBit] = (dn_cnt_d != 3'd0);
          pressed_d = pressed_q | edge_flags;
          for (int i = 0; i < NumChan; i++) begin
            lvl_d[i] = ramp(lvl_q[i], tgt_q[i], step_q);
          end
        end
        OP_WR_BYTE: begin
          tgt_d[slot_q] = req_i.wr_data;
          slot_d        = slot_q + 2'd1;
        end
        OP_WR_STOP: begin
          step_d = tgt_q[SpeedSlot];
          slot_d = 2'd0;
        end
        OP_RD_PRESSED: begin
          rd_data = pressed_q;
          if ((up_cnt_q != 3'd0) && pressed_q[UpBit]) begin
            up_cnt_d = up_cnt_q - 3'd1;
          end
          if ((dn_cnt_q != 3'd0) && pressed_q[DownBit]) begin
            dn_cnt_d = dn_cnt_q - 3'd1;
          end
          pressed_d = 8'd0;
        end
        OP_RD_HELD: begin
          rd_data = {2'b00, held_q};
        end
        default: begin
        end
      endcase
    end
  end

  assign rsp_o.rd_data     = rd_data;
  assign rsp_o.red_level   = lvl_d[0];
  assign rsp_o.green_level = lvl_d[1];
  assign rsp_o.blue_level  = lvl_d[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= HoldTicksReset;
      prev_down_q <= '0;
      up_cnt_q    <= '0;
      dn_cnt_q    <= '0;
      pressed_q   <= '0;
      held_q      <= '0;
      step_q      <= '0;
      slot_q      <= '0;
      for (int i = 0; i < NumBtn; i++) begin
        cnt_q[i] <= '0;
      end
      for (int i = 0; i < NumTgt; i++) begin
        tgt_q[i] <= '0;
      end
      for (int i = 0; i < NumChan; i++) begin
        lvl_q[i] <= '0;
      end
    end else begin
      hold_q      <= hold_d;
      prev_down_q <= prev_down_d;
      up_cnt_q    <= up_cnt_d;
      dn_cnt_q    <= dn_cnt_d;
      pressed_q   <= pressed_d;
      held_q      <= held_d;
      step_q      <= step_d;
      slot_q      <= slot_d;
      for (int i = 0; i < NumBtn; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
      for (int i = 0; i < NumTgt; i++) begin
        tgt_q[i] <= tgt_d[i];
      end
      for (int i = 0; i < NumChan; i++) begin
        lvl_q[i] <= lvl_d[i];
      end
    end
  end

endmodule

`default_nettype wire

[sv/front_panel_button_led_controller_top.sv]
// Channel   Direction  Handshake            Payload
// in        in         in_valid_i/in_stall_o    fpbl_in_t  (op, buttons, scroll, write byte)
// out       out        out_valid_o/out_stall_i  fpbl_out_t (read byte, RGB levels)
// cfg       in         cfg_valid_i/cfg_ready_o  hold time, 7 bits
//
// One request per cycle while the output is not stalled; a taken request passes
// through the input register, then the single-pass update into the result register.
// Reset clears all button, scroll, flag and LED state; hold time resets to 32 ticks.
// A stalled result holds the input register, which then stalls new requests.
// Configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none
`include "front_panel_button_led_controller_top_assert.svh"

module front_panel_button_led_controller_top
  import fpbl_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire fpbl_in_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output fpbl_out_t       out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [6:0] cfg_data_i
);

  logic      s1_valid_q, s1_valid_d;
  fpbl_in_t  s1_q;
  logic      out_valid_q, out_valid_d;
  fpbl_out_t out_q;
  fpbl_out_t rsp;
  logic      adv;
  logic      in_take;

  assign adv         = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !adv;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  fpbl_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .req_i      (s1_q),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_data_i;
    end
    if (adv) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FPBL_ASSERT(a_stall_needs_req, !in_stall_o || (out_valid_q && out_stall_i), "bad stall")
  `FPBL_ASSERT_NEXT(a_adv_loads_out, adv, out_valid_o, "advanced request left no result")
  `FPBL_ASSERT_NEXT(a_rd_zero_else,
    adv && (s1_q.op != OP_RD_PRESSED) && (s1_q.op != OP_RD_HELD),
    out_data_o.rd_data == 8'd0, "read byte nonzero on a non-read request")

endmodule

`default_nettype wire
